### rtl/psc_pkg.sv
// Package for the prime and super-prime classifier.
// Holds the sequencer state type, fixed widths and the small-prime lookup.
// No dependencies.
package psc_pkg;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_COUNT = 5'b00010,
      S_DSUM  = 5'b00100,
      S_TRIAL = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   // Digit sum of a 64-bit value stays below 256, bit count below 128
   localparam int DSUM_W = 8;
   localparam int BCNT_W = 7;

   // Field widths of the result beat
   localparam int DIGIT_SUM_W = 7;
   localparam int ONE_COUNT_W = 6;

   // Divisors used by the sequencer
   localparam int DIGIT_BASE = 10;
   localparam int FIRST_DIV  = 3;
   localparam int SECOND_DIV = 5;

   // Primality of a small value (digit sum or bit count)
   function automatic logic is_small_prime(input logic [DSUM_W-1:0] v);
      logic res;
      res = 1'b0;
      case (v)
         8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29,
         8'd31, 8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59, 8'd61, 8'd67,
         8'd71, 8'd73, 8'd79, 8'd83, 8'd89, 8'd97, 8'd101, 8'd103, 8'd107,
         8'd109, 8'd113, 8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151,
         8'd157, 8'd163, 8'd167, 8'd173, 8'd179, 8'd181, 8'd191, 8'd193,
         8'd197, 8'd199, 8'd211, 8'd223, 8'd227, 8'd229, 8'd233, 8'd239,
         8'd241, 8'd251: res = 1'b1;
         default:        res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

### rtl/prime_and_super_prime_classifier_core.sv
// Prime and super-prime classifier: top level.
// One shared restoring divider under a small sequencer; uses psc_pkg.
//
//  channel  | direction | handshake              | payload
//  req_     | in        | req_valid / req_ready  | req_value
//  rsp_     | out       | rsp_valid / rsp_ready  | seven classification fields
//
// Steps per beat: idle takes the beat, count tallies the one bits one by one, then one
// division per decimal digit (at least one digit) for the digit sum, then one division
// per trial divisor (3, 5, 7, 11, 13, ...) up to the square root for odd values above 3;
// done then moves the result into the output register.
// Reset is synchronous and empties the sequencer and the output register; req_ready is
// high only when idle, and the sequencer stalls in done while an earlier result still
// waits on rsp_ for rsp_ready.
module prime_and_super_prime_classifier_core #(
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [VALUE_BITS-1:0]                req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_value_is_prime,
   output logic [psc_pkg::DIGIT_SUM_W-1:0]      rsp_digit_sum,
   output logic                                 rsp_digit_sum_is_prime,
   output logic [psc_pkg::ONE_COUNT_W-1:0]      rsp_one_bit_count,
   output logic                                 rsp_bit_count_is_prime,
   output logic                                 rsp_super_prime,
   output logic                                 rsp_super_b_prime
);
   import psc_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(VALUE_BITS - 1);
   localparam logic [VALUE_BITS-1:0] DEN_BASE   = VALUE_BITS'(DIGIT_BASE);
   localparam logic [VALUE_BITS-1:0] DEN_FIRST  = VALUE_BITS'(FIRST_DIV);
   localparam logic [VALUE_BITS-1:0] DEN_SECOND = VALUE_BITS'(SECOND_DIV);

   state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]   num_ff, num_in;
   logic [VALUE_BITS-1:0]   shift_ff, shift_in;
   logic [BCNT_W-1:0]       bits_ff, bits_in;
   logic [VALUE_BITS-1:0]   dvd_ff, dvd_in;
   logic [VALUE_BITS-1:0]   rem_ff, rem_in;
   logic [VALUE_BITS-1:0]   den_ff, den_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    step4_ff, step4_in;
   logic [DSUM_W-1:0]       ds_ff, ds_in;
   logic                    vp_ff, vp_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_vp_ff, out_vp_in;
   logic [DSUM_W-1:0]       out_ds_ff, out_ds_in;
   logic [BCNT_W-1:0]       out_bits_ff, out_bits_in;
   logic                    res_load;

   // Shared divider step: one quotient bit per cycle
   logic [VALUE_BITS:0]     rem_sh;
   logic                    div_ge;
   logic [VALUE_BITS:0]     rem_nx;
   logic [VALUE_BITS-1:0]   rem_w;
   logic [VALUE_BITS-1:0]   dvd_nx;
   logic                    div_last;
   logic                    dsp, bcp;

   assign rem_sh   = {rem_ff, dvd_ff[VALUE_BITS-1]};
   assign div_ge   = rem_sh >= {1'b0, den_ff};
   assign rem_nx   = div_ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
   assign rem_w    = rem_nx[VALUE_BITS-1:0];
   assign dvd_nx   = {dvd_ff[VALUE_BITS-2:0], div_ge};
   assign div_last = (cnt_ff == LAST_CNT);

   // Move a finished result out once the output register is free
   assign res_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      step4_in = step4_ff;
      ds_in    = ds_ff;
      vp_in    = vp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               num_in   = req_value;
               shift_in = req_value;
               bits_in  = '0;
               cnt_in   = '0;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            // count one bits, one per cycle
            bits_in  = bits_ff + BCNT_W'(shift_ff[0]);
            shift_in = shift_ff >> 1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (div_last) begin
               dvd_in   = num_ff;
               rem_in   = '0;
               den_in   = DEN_BASE;
               cnt_in   = '0;
               ds_in    = '0;
               state_in = S_DSUM;
            end
         end
         S_DSUM: begin
            // peel one decimal digit per division
            dvd_in = dvd_nx;
            rem_in = rem_w;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               ds_in  = ds_ff + DSUM_W'(rem_w[3:0]);
               rem_in = '0;
               cnt_in = '0;
               if (dvd_nx == '0) begin
                  // start the primality test of the value
                  if (num_ff < VALUE_BITS'(2)) begin
                     vp_in    = 1'b0;
                     state_in = S_DONE;
                  end else if (num_ff == VALUE_BITS'(2) || num_ff == VALUE_BITS'(3)) begin
                     vp_in    = 1'b1;
                     state_in = S_DONE;
                  end else if (!num_ff[0]) begin
                     vp_in    = 1'b0;
                     state_in = S_DONE;
                  end else begin
                     dvd_in   = num_ff;
                     den_in   = DEN_FIRST;
                     step4_in = 1'b0;
                     state_in = S_TRIAL;
                  end
               end
            end
         end
         S_TRIAL: begin
            // divide by the current trial divisor
            dvd_in = dvd_nx;
            rem_in = rem_w;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               rem_in = '0;
               cnt_in = '0;
               dvd_in = num_ff;
               if (den_ff > dvd_nx) begin
                  vp_in    = 1'b1;
                  state_in = S_DONE;
               end else if (rem_w == '0) begin
                  vp_in    = 1'b0;
                  state_in = S_DONE;
               end else if (den_ff == DEN_FIRST) begin
                  den_in   = DEN_SECOND;
                  step4_in = 1'b0;
               end else begin
                  // advance along 6k-1 / 6k+1
                  den_in   = den_ff + (step4_ff ? VALUE_BITS'(4) : VALUE_BITS'(2));
                  step4_in = !step4_ff;
               end
            end
         end
         S_DONE: begin
            if (res_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: drop a taken beat, load a finished result
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_vp_in    = out_vp_ff;
      out_ds_in    = out_ds_ff;
      out_bits_in  = out_bits_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_load) begin
         rsp_valid_in = 1'b1;
         out_vp_in    = vp_ff;
         out_ds_in    = ds_ff;
         out_bits_in  = bits_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      shift_ff    <= shift_in;
      bits_ff     <= bits_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      cnt_ff      <= cnt_in;
      step4_ff    <= step4_in;
      ds_ff       <= ds_in;
      vp_ff       <= vp_in;
      out_vp_ff   <= out_vp_in;
      out_ds_ff   <= out_ds_in;
      out_bits_ff <= out_bits_in;
   end

   // Result beat
   assign dsp = is_small_prime(out_ds_ff);
   assign bcp = is_small_prime(DSUM_W'(out_bits_ff));

   assign req_ready              = (state_ff == S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_value_is_prime     = out_vp_ff;
   assign rsp_digit_sum          = (out_ds_ff > DSUM_W'(127)) ? DIGIT_SUM_W'(127)
                                                              : out_ds_ff[DIGIT_SUM_W-1:0];
   assign rsp_digit_sum_is_prime = dsp;
   assign rsp_one_bit_count      = (out_bits_ff > BCNT_W'(63)) ? ONE_COUNT_W'(63)
                                                               : out_bits_ff[ONE_COUNT_W-1:0];
   assign rsp_bit_count_is_prime = bcp;
   assign rsp_super_prime        = out_vp_ff & dsp;
   assign rsp_super_b_prime      = out_vp_ff & dsp & bcp;

endmodule
